/* hdl/nlms_echo_canceller_core_macros.svh */
// assertion macros for the nlms echo canceller core
`ifndef NLMS_ECHO_CANCELLER_CORE_MACROS_SVH
`define NLMS_ECHO_CANCELLER_CORE_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define NEC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication checked outside reset
`define NEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

/* hdl/nlms_pkg.sv */
// ----------------------------------------------------------------------------
// nlms_pkg
// shared widths, register indexes and reset values of the echo canceller
// ----------------------------------------------------------------------------
package nlms_pkg;
  localparam int TapsDefault = 700;
  localparam int SampleW = 16;
  localparam int WeightW = 32;
  localparam int CfgDataW = 32;
  localparam int CfgIdxW = 2;
  localparam int FlenW = 13;

  localparam logic [CfgIdxW-1:0] RegStepSize = 2'd0;
  localparam logic [CfgIdxW-1:0] RegRegularization = 2'd1;
  localparam logic [CfgIdxW-1:0] RegFrameSamples = 2'd2;

  localparam logic [15:0] StepSizeReset = 16'd16384;
  localparam logic [31:0] RegularizationReset = 32'd3;
  localparam logic [FlenW-1:0] FrameSamplesReset = 13'd128;

  // quotient width of the gain divider (gain clamps at 2^40)
  localparam int GainW = 41;
endpackage

/* hdl/nlms_div.sv */
// ----------------------------------------------------------------------------
// nlms_div
// restoring divider, one quotient bit per cycle, saturating quotient
// ----------------------------------------------------------------------------
module nlms_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [48:0] divisor,
  output logic        done,
  output logic [nlms_pkg::GainW-1:0] quotient
);
  import nlms_pkg::*;

  logic [63:0] quo_r, quo_nxt;
  logic [49:0] rem_r, rem_nxt;
  logic [48:0] dsr_r, dsr_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [49:0] trial;

  // one shift-subtract step per cycle
  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    dsr_nxt = dsr_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r[48:0], quo_r[63]} - {1'b0, dsr_r};
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      dsr_nxt = divisor;
      cnt_nxt = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[49]) begin
        rem_nxt = trial;
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[48:0], quo_r[63]};
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done = done_r;
  // clamp to 2^40
  assign quotient = (quo_r > 64'h100_0000_0000) ? GainW'(64'h100_0000_0000)
                                                 : quo_r[GainW-1:0];
endmodule

/* hdl/nlms_ctrl.sv */
// ----------------------------------------------------------------------------
// nlms_ctrl
// sequencer: history write, filter pass, power test, divide, weight update
// ----------------------------------------------------------------------------
module nlms_ctrl #(
  parameter int TAPS = nlms_pkg::TapsDefault,
  parameter int AW = $clog2(TAPS)
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [nlms_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [nlms_pkg::CfgDataW-1:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [15:0] in_ref,
  input  logic signed [15:0] in_mic,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [15:0] out_err,
  output logic        out_adapted
);
  import nlms_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RDOLD, S_WROLD, S_FILT, S_FDRAIN, S_TEST, S_TEST2, S_DIV, S_DIVW,
    S_UPD, S_UDRAIN, S_OUT
  } state_t;

  state_t state_r;

  // memories
  logic signed [WeightW-1:0] wmem [TAPS];
  logic signed [SampleW-1:0] hmem [TAPS];
  logic signed [WeightW-1:0] wrd_r;
  logic signed [SampleW-1:0] hrd_r;
  logic [AW-1:0] wra, hra, wwa, hwa;
  logic wwe, hwe;
  logic signed [WeightW-1:0] wwd;
  logic signed [SampleW-1:0] hwd;

  // clearing pass after reset
  logic clr_r;
  logic [AW-1:0] clr_cnt_r;

  logic [15:0] step_r;
  logic [31:0] reg_r;
  logic [FlenW-1:0] flen_r;

  logic [AW-1:0] ptr_r, tidx_r, widx_r;
  logic [AW:0]   m_r;
  logic          rdv_r;
  logic [AW-1:0] rdw_r;
  logic signed [15:0] x0_r, mic_r;
  logic [39:0] wpow_r;
  logic [42:0] fpow_r;
  logic [12:0] fcnt_r;
  logic [63:0] tpow_r;
  logic [31:0] tcnt_r;
  logic signed [63:0] acc_r;
  logic signed [47:0] prod_r;
  logic          pv_r;
  logic signed [15:0] err_r;
  logic          adapt_r;
  logic [127:0]  lhs_r, rhs_r;
  logic [1:0]    tstep_r;
  logic [63:0]   mul_a_r;
  logic [31:0]   mul_b_r;
  logic [63:0]   part_r;
  logic [GainW-1:0] g_r;

  // divider
  logic div_start, div_done;
  logic [GainW-1:0] div_q;
  logic [63:0] div_n;
  logic [48:0] div_d;

  nlms_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_n),
    .divisor(div_d), .done(div_done), .quotient(div_q)
  );

  // newest-first tap index walking down from the pointer
  function automatic logic [AW-1:0] dec_idx(input logic [AW-1:0] i);
    return (i == '0) ? AW'(TAPS - 1) : i - AW'(1);
  endfunction

  logic [31:0] sq;
  logic [31:0] old_sq;
  logic [FlenW-1:0] flen_eff;
  always_comb begin
    sq = 32'(x0_r) * 32'(x0_r);
    old_sq = 32'(hrd_r) * 32'(hrd_r);
    flen_eff = (flen_r == '0) ? FlenW'(1) : flen_r;
  end

  // update path: combinational product then rounding and saturation
  logic [56:0] gx;
  logic [47:0] dw;
  logic signed [49:0] nw;
  logic xneg;
  logic [15:0] xmag;
  always_comb begin
    xneg = hrd_r[15];
    xmag = xneg ? 16'(-hrd_r) : hrd_r;
    gx = 57'(g_r) * 57'(xmag);
    dw = 48'((gx + 57'd256) >> 9);
    if (xneg != err_r[15]) nw = 50'($signed(wrd_r)) - $signed({2'b0, dw});
    else                   nw = 50'($signed(wrd_r)) + $signed({2'b0, dw});
  end
  logic signed [31:0] nw_sat;
  always_comb begin
    if (nw > 50'sh7FFFFFFF) nw_sat = 32'h7FFFFFFF;
    else if (nw < -50'sh80000000) nw_sat = 32'h80000000;
    else nw_sat = nw[31:0];
  end

  // error rounding and saturation
  logic signed [64:0] efull;
  logic signed [34:0] eshift;
  always_comb begin
    efull = ($signed(65'(mic_r)) <<< 30) - 65'(acc_r) + 65'sd536870912;
    eshift = 35'(efull >>> 30);
  end

  logic [15:0] emag;
  assign emag = err_r[15] ? 16'(-err_r) : err_r;
  assign div_n = {32'(step_r) * 32'(emag), 32'd0};
  assign div_d = 49'(reg_r) + {1'b0, wpow_r, 8'd0};

  // memory ports
  always_ff @(posedge clk) begin
    if (wwe) wmem[wwa] <= wwd;
    if (hwe) hmem[hwa] <= hwd;
    wrd_r <= wmem[wra];
    hrd_r <= hmem[hra];
  end

  always_comb begin
    hra = tidx_r;
    wra = widx_r;
    hwe = 1'b0; hwa = ptr_r; hwd = x0_r;
    wwe = 1'b0; wwa = rdw_r; wwd = nw_sat;
    div_start = 1'b0;
    if (clr_r) begin
      hwe = 1'b1; hwa = clr_cnt_r; hwd = '0;
      wwe = 1'b1; wwa = clr_cnt_r; wwd = '0;
    end else begin
      if (state_r == S_WROLD) hwe = 1'b1;
      if (state_r == S_UDRAIN && rdv_r) wwe = 1'b1;
      if (state_r == S_UPD && rdv_r) wwe = 1'b1;
      if (state_r == S_TEST2 && lhs_r > rhs_r && div_d != '0) div_start = 1'b1;
    end
  end

  assign in_ready = (state_r == S_IDLE) && !clr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      clr_r <= 1'b1;
      clr_cnt_r <= '0;
      step_r <= StepSizeReset;
      reg_r <= RegularizationReset;
      flen_r <= FrameSamplesReset;
      ptr_r <= '0;
      wpow_r <= '0; fpow_r <= '0; fcnt_r <= '0; tpow_r <= '0; tcnt_r <= '0;
      out_valid <= 1'b0;
      rdv_r <= 1'b0; pv_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          RegStepSize: step_r <= cfg_data[15:0];
          RegRegularization: reg_r <= cfg_data;
          RegFrameSamples: flen_r <= cfg_data[FlenW-1:0];
          default: ;
        endcase
      end
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(TAPS - 1)) clr_r <= 1'b0;
      end
      // the output step reloads the result register itself
      if (out_valid && out_ready && state_r != S_OUT) out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            x0_r <= in_ref; mic_r <= in_mic;
            tidx_r <= ptr_r;
            state_r <= S_RDOLD;
          end
        end
        S_RDOLD: state_r <= S_WROLD;
        S_WROLD: begin
          // leaving sample is on the read port; account and write newest
          wpow_r <= wpow_r + 40'(sq) - 40'(old_sq);
          if (fcnt_r >= 13'(flen_eff)) begin
            fpow_r <= 43'(sq); fcnt_r <= 13'd1;
          end else begin
            fpow_r <= fpow_r + 43'(sq); fcnt_r <= fcnt_r + 13'd1;
          end
          tpow_r <= (tpow_r > ~64'(sq)) ? '1 : tpow_r + 64'(sq);
          if (tcnt_r != '1) tcnt_r <= tcnt_r + 32'd1;
          acc_r <= '0; pv_r <= 1'b0;
          m_r <= '0; tidx_r <= ptr_r; widx_r <= '0; rdv_r <= 1'b0;
          state_r <= S_FILT;
        end
        S_FILT: begin
          // read issue, then product, then accumulate
          if (pv_r) acc_r <= acc_r + 64'(prod_r);
          pv_r <= rdv_r;
          prod_r <= 48'(wrd_r) * 48'(hrd_r);
          rdv_r <= 1'b1;
          tidx_r <= dec_idx(tidx_r);
          widx_r <= widx_r + AW'(1);
          m_r <= m_r + (AW+1)'(1);
          if (m_r == (AW+1)'(TAPS - 1)) state_r <= S_FDRAIN;
        end
        S_FDRAIN: begin
          if (pv_r) acc_r <= acc_r + 64'(prod_r);
          pv_r <= rdv_r;
          prod_r <= 48'(wrd_r) * 48'(hrd_r);
          rdv_r <= 1'b0;
          if (!rdv_r && !pv_r) state_r <= S_TEST;
        end
        S_TEST: begin
          if (eshift > 35'sd32767) err_r <= 16'sh7FFF;
          else if (eshift < -35'sd32768) err_r <= -16'sh8000;
          else err_r <= eshift[15:0];
          // compare via split products over cycles
          mul_a_r <= 64'(fpow_r); mul_b_r <= tcnt_r; tstep_r <= 2'd0;
          lhs_r <= '0; rhs_r <= '0;
          adapt_r <= 1'b0;
          state_r <= S_TEST2;
        end
        S_TEST2: begin
          // lhs/rhs built in four 32x32 partial products
          unique case (tstep_r)
            2'd0: begin
              lhs_r <= 128'(64'(mul_a_r[31:0]) * 64'(mul_b_r));
              tstep_r <= 2'd1; state_r <= S_TEST2;
            end
            2'd1: begin
              lhs_r <= lhs_r + (128'(64'(mul_a_r[63:32]) * 64'(mul_b_r)) << 32);
              mul_a_r <= tpow_r; mul_b_r <= 32'(fcnt_r);
              tstep_r <= 2'd2;
            end
            2'd2: begin
              rhs_r <= 128'(64'(mul_a_r[31:0]) * 64'(mul_b_r));
              tstep_r <= 2'd3;
            end
            default: begin
              rhs_r <= rhs_r + (128'(64'(mul_a_r[63:32]) * 64'(mul_b_r)) << 32);
              tstep_r <= 2'd0;
              state_r <= S_DIV;
            end
          endcase
        end
        S_DIV: begin
          state_r <= S_DIVW;
          if (!(lhs_r > rhs_r && div_d != '0)) state_r <= S_OUT;
        end
        S_DIVW: begin
          if (div_done) begin
            g_r <= div_q; adapt_r <= 1'b1;
            m_r <= '0; tidx_r <= ptr_r; widx_r <= '0; rdv_r <= 1'b0;
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          rdv_r <= 1'b1; rdw_r <= widx_r;
          tidx_r <= dec_idx(tidx_r);
          widx_r <= widx_r + AW'(1);
          m_r <= m_r + (AW+1)'(1);
          if (m_r == (AW+1)'(TAPS - 1)) state_r <= S_UDRAIN;
        end
        S_UDRAIN: begin
          rdv_r <= 1'b0;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_err <= err_r; out_adapted <= adapt_r;
            ptr_r <= (ptr_r == AW'(TAPS - 1)) ? '0 : ptr_r + AW'(1);
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

/* hdl/nlms_echo_canceller_core.sv */
// ----------------------------------------------------------------------------
// nlms_echo_canceller_core
// nlms acoustic echo canceller, one sample pair per request
// ----------------------------------------------------------------------------
// usage:
//   in_* channel carries {mic_sample, reference_sample}; out_* carries
//   {error_sample} in tdata and adapted in tuser.
//   each request walks the taps over the weight and history memories for the
//   filter pass and error, then runs the power test and the decision, and
//   when adapting the gain divider and a second walk for the weight update.
//   one request is handled at a time; the next request can be taken in the
//   cycle the result is presented.
//   after reset a clearing pass zeroes both memories; in_tready stays low
//   until it ends. configuration writes are taken at any time.
//   the result sits in an output register; the next request is taken while
//   it waits, and a stalled receiver holds the core in its output step only
//   once the result after it is ready.
// ----------------------------------------------------------------------------
module nlms_echo_canceller_core #(
  parameter int TAPS = nlms_pkg::TapsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [nlms_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [nlms_pkg::CfgDataW-1:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] reference_sample, [31:16] mic_sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] error_sample
  output logic        out_tuser   // [0] adapted
);
  import nlms_pkg::*;

  logic signed [15:0] err;

  nlms_ctrl #(.TAPS(TAPS)) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .in_ref(in_tdata[15:0]), .in_mic(in_tdata[31:16]),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_err(err), .out_adapted(out_tuser)
  );

  assign out_tdata = err;
endmodule

/* hdl/nlms_checker.sv */
// ----------------------------------------------------------------------------
// nlms_checker
// port-level checks of the echo canceller handshake and sequencing
// ----------------------------------------------------------------------------
`include "nlms_echo_canceller_core_macros.svh"
module nlms_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);
  // one request in flight: no new request right after one is taken
  `NEC_ASSERT_NEXT(a_single, clk, rst_n, in_tvalid && in_tready, !in_tready)
  // no result the cycle after a request is taken with no result waiting
  `NEC_ASSERT_NEXT(a_nolat0, clk, rst_n, in_tvalid && in_tready && !out_tvalid, !out_tvalid)
  // a stalled result holds
  `NEC_ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready,
                   out_tvalid && $stable(out_tdata))
endmodule

bind nlms_echo_canceller_core nlms_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

/* dv/tb_nlms_echo_canceller_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nlms_echo_canceller_core
// stream-level check of the nlms echo canceller core
// ----------------------------------------------------------------------------
// a bit-exact software copy of the canceller (history, weights, power sums)
// predicts error_sample and adapted for every accepted request; results are
// compared in order. directed corners come first, then frame-length changes,
// then random bursts of varying loudness under several register settings,
// with random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_nlms_echo_canceller_core;
  import nlms_pkg::*;

  localparam int Taps = TapsDefault;
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

  typedef struct packed {
    logic [15:0] error_sample;
    logic        adapted;
  } echo_result_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic                in_tvalid;
  logic                in_tready;
  logic [31:0]         in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [15:0]         out_tdata;
  logic                out_tuser;

  nlms_echo_canceller_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // canceller state as seen by the predictor
  int                  weight_q30 [Taps];
  shortint             ref_history [Taps];
  int unsigned         hist_slot;
  longint unsigned     window_pow;
  longint unsigned     frame_pow;
  int unsigned         frame_cnt;
  longint unsigned     longrun_pow;
  int unsigned         longrun_cnt;
  logic [15:0]         mu_q15;
  logic [31:0]         reg_a;
  logic [FlenW-1:0]    frame_len;

  echo_result_t        pending_results [$];
  int                  mismatch_cnt;

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // one request through the predictor
  function automatic echo_result_t predict_echo_cancel(logic [15:0] ref_in, logic [15:0] mic_in);
    echo_result_t    res;
    int              x0;
    int              mic;
    int unsigned     slot;
    int unsigned     flen;
    int              leaving;
    longint unsigned sq;
    longint          acc;
    longint          efull;
    int              err;
    logic [127:0]    lhs;
    logic [127:0]    rhs;
    longint unsigned divisor;
    longint unsigned mag;
    longint unsigned gain;
    longint unsigned xm;
    longint          dw;
    longint          nw;
    int              x;
    int unsigned     idx;
    bit              adapt;
    x0 = int'($signed(ref_in));
    mic = int'($signed(mic_in));
    slot = (hist_slot < Taps) ? hist_slot : 0;
    flen = (frame_len != 0) ? int'(frame_len) : 1;
    leaving = ref_history[slot];
    sq = longint'(x0) * longint'(x0);
    adapt = 1'b0;

    ref_history[slot] = shortint'(x0);
    window_pow = window_pow + sq - longint'(leaving) * longint'(leaving);

    // frame and long-run power sums
    if (frame_cnt >= flen) begin
      frame_pow = 0;
      frame_cnt = 0;
    end
    frame_pow += sq;
    frame_cnt++;
    longrun_pow = (longrun_pow > ~64'd0 - sq) ? ~64'd0 : longrun_pow + sq;
    if (longrun_cnt != 32'hFFFF_FFFF) longrun_cnt++;

    // filter estimate with the weights from before the update
    acc = 0;
    for (int m = 0; m < Taps; m++) begin
      idx = (slot >= m) ? slot - m : slot + Taps - m;
      acc += longint'(weight_q30[idx == idx ? m : m]) * longint'(ref_history[idx]);
    end
    efull = longint'(mic) * (longint'(1) <<< 30) - acc;
    efull = (efull + (longint'(1) <<< 29)) >>> 30;
    if (efull > 32767) efull = 32767;
    if (efull < -32768) efull = -32768;
    err = int'(efull);

    // adapt only while the frame is louder than the long-run mean
    lhs = 128'(frame_pow) * 128'(longrun_cnt);
    rhs = 128'(longrun_pow) * 128'(frame_cnt);
    if (lhs > rhs) begin
      divisor = longint'(reg_a) + (window_pow << 8);
      if (divisor != 0) begin
        mag = (err < 0) ? longint'(-err) : longint'(err);
        gain = ((longint'(mu_q15) * mag) << 32) / divisor;
        if (gain > (64'd1 << 40)) gain = 64'd1 << 40;
        adapt = 1'b1;
        for (int m = 0; m < Taps; m++) begin
          idx = (slot >= m) ? slot - m : slot + Taps - m;
          x = ref_history[idx];
          xm = (x < 0) ? longint'(-x) : longint'(x);
          dw = longint'((gain * xm + 64'd256) >> 9);
          if ((x < 0) != (err < 0)) dw = -dw;
          nw = longint'(weight_q30[m]) + dw;
          if (nw > 64'sd2147483647) nw = 64'sd2147483647;
          if (nw < -64'sd2147483648) nw = -64'sd2147483648;
          weight_q30[m] = int'(nw);
        end
      end
    end

    hist_slot = (slot + 1 >= Taps) ? 0 : slot + 1;
    res.error_sample = err[15:0];
    res.adapted = adapt;
    return res;
  endfunction

  // result checker
  always @(posedge clk) begin
    echo_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: error_sample=%0d adapted=%0b",
                   $signed(out_tdata), out_tuser);
      end else begin
        want = pending_results.pop_front();
        if (want.error_sample !== out_tdata || want.adapted !== out_tuser) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("result mismatch: error_sample exp %0d got %0d, adapted exp %0b got %0b",
                     $signed(want.error_sample), $signed(out_tdata), want.adapted, out_tuser);
        end
      end
    end
  end

  // receiver stalls: runs of ready and not ready, mostly short
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= ($urandom_range(0, 99) < 70);
      if ($urandom_range(0, 19) == 0) stall_left <= $urandom_range(30, 200);
      else stall_left <= $urandom_range(0, 4);
    end
  end

  // one request, held until taken
  task automatic send_sample_pair(logic [15:0] ref_in, logic [15:0] mic_in);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {mic_in, ref_in};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_echo_cancel(ref_in, mic_in));
  endtask

  // stop sending and wait for every result
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      RegStepSize:       mu_q15 = value[15:0];
      RegRegularization: reg_a = value;
      RegFrameSamples:   frame_len = value[FlenW-1:0];
      default: ;
    endcase
  endtask

  // silence with a zero divisor, then full-scale corners
  task automatic test_directed_corners();
    write_register(RegRegularization, 32'd0);
    send_sample_pair(16'd0, 16'd0);
    send_sample_pair(16'd0, 16'h7FFF);
    send_sample_pair(16'd0, 16'h8000);
    write_register(RegRegularization, RegularizationReset);
    send_sample_pair(16'h7FFF, 16'h7FFF);
    send_sample_pair(16'h8000, 16'h8000);
    send_sample_pair(16'h7FFF, 16'h8000);
    send_sample_pair(16'h8000, 16'h7FFF);
    send_sample_pair(16'h0001, 16'hFFFF);
    send_sample_pair(16'hFFFF, 16'h0000);
    send_sample_pair(16'h5555, 16'hAAAA);
    send_sample_pair(16'hAAAA, 16'h5555);
    // a zero pair; frame and long-run sums still match, so no update is made
    send_sample_pair(16'h0000, 16'h0000);
  endtask

  // frame shortened mid-frame, zero frame length, ignored register index
  task automatic test_frame_length_changes();
    write_register(RegFrameSamples, 32'd128);
    for (int i = 0; i < 4; i++) send_sample_pair(16'($urandom), 16'($urandom));
    write_register(RegFrameSamples, 32'd2);
    for (int i = 0; i < 3; i++) send_sample_pair(16'($urandom), 16'($urandom));
    write_register(RegFrameSamples, 32'd0);
    write_register(RegUnused, 32'hFFFF_FFFF);
    for (int i = 0; i < 3; i++) send_sample_pair(16'($urandom), 16'($urandom));
  endtask

  // random bursts whose loudness changes so that the power test flips
  task automatic run_random_bursts(int items);
    int   shift;
    int   echo_gain;
    int   r;
    int   mic;
    logic [15:0] rs;
    for (int i = 0; i < items; i++) begin
      if (i % 8 == 0) begin
        shift = $urandom_range(0, 14);
        echo_gain = $urandom_range(0, 7);
      end
      if ($urandom_range(0, 9) == 0) begin
        send_sample_pair(16'($urandom), 16'($urandom));
      end else begin
        r = int'($signed(16'($urandom))) >>> shift;
        mic = (r * echo_gain) / 8 + int'($urandom_range(0, 15)) - 8;
        rs = r[15:0];
        send_sample_pair(rs, mic[15:0]);
      end
    end
  endtask

  // register settings from one extreme to the other
  task automatic test_register_sweep();
    write_register(RegStepSize, 32'd65535);
    write_register(RegRegularization, 32'd0);
    write_register(RegFrameSamples, 32'd1);
    run_random_bursts(70);
    write_register(RegStepSize, 32'd0);
    write_register(RegRegularization, 32'hFFFF_FFFF);
    write_register(RegFrameSamples, 32'd4096);
    run_random_bursts(60);
    write_register(RegStepSize, 32'd1200);
    write_register(RegRegularization, 32'd3000);
    write_register(RegFrameSamples, 32'd16);
    run_random_bursts(90);
    write_register(RegStepSize, 32'd40000);
    write_register(RegRegularization, 32'h0001_0000);
    write_register(RegFrameSamples, 32'd5);
    run_random_bursts(90);
    write_register(RegStepSize, {16'd0, StepSizeReset});
    write_register(RegRegularization, RegularizationReset);
    write_register(RegFrameSamples, {19'd0, FrameSamplesReset});
    run_random_bursts(90);
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= RegStepSize;
    cfg_data <= '0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    mismatch_cnt = 0;
    foreach (weight_q30[i]) weight_q30[i] = 0;
    foreach (ref_history[i]) ref_history[i] = 0;
    hist_slot = 0;
    window_pow = 0;
    frame_pow = 0;
    frame_cnt = 0;
    longrun_pow = 0;
    longrun_cnt = 0;
    mu_q15 = StepSizeReset;
    reg_a = RegularizationReset;
    frame_len = FrameSamplesReset;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_corners();
    test_frame_length_changes();
    test_register_sweep();
    drain_results();
    repeat (50) @(posedge clk);

    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #60ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/nlms_pkg.sv
hdl/nlms_div.sv
hdl/nlms_ctrl.sv
hdl/nlms_echo_canceller_core.sv
hdl/nlms_checker.sv
dv/tb_nlms_echo_canceller_core.sv
